### hw/rtl/bttp_pkg.sv
// Shared constants for the bearing-to-point block: datapath width and arctangent table.
package bttp_pkg;

    // Width of the offset and rotation datapath. The offset needs 34 bits, and the
    // rotation gain and the half-turn pre-rotation add under three more.
    localparam int DATA_W = 40;

    // Number of entries in the arctangent table.
    localparam int TABLE_LEN = 24;

    // Width of the bearing result.
    localparam int OUT_W = 16;

    // Special-case bearings, in 1/65536 turn.
    localparam logic [OUT_W-1:0] BEARING_NORTH = 16'h0000;
    localparam logic [OUT_W-1:0] BEARING_EAST  = 16'h4000;
    localparam logic [OUT_W-1:0] BEARING_SOUTH = 16'h8000;
    localparam logic [OUT_W-1:0] BEARING_WEST  = 16'hC000;

    typedef logic [31:0] atan_q32_t;

    // atan(2^-i) / (2*pi) in Q0.32 turns.
    localparam atan_q32_t ATAN_TURNS_Q32 [TABLE_LEN] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81
    };

endpackage

### hw/rtl/bearing_to_point_turns.sv
// Pipelined bearing from an agent's centre to a target point, in fractions of a turn.
//
// Usage: an item on the s_ channel carries the agent's top-left corner and size and a
// target point, with positions in signed Q24.8 pixels and y growing downward. The m_
// channel returns one item per input item: m_bearing, the clockwise angle from north
// in units of 1/65536 turn (east 0x4000, south 0x8000, west 0xC000). A zero offset
// gives 0. Both channels use valid/ready; an item moves when valid and ready are high.
// An item passes the offset register, the set-up register (vector and special cases),
// one register per CORDIC rotation stage (min(ROTATION_STAGES, 24) of them) and the
// output register, which takes the rounded angle. Throughput is one item per cycle
// while m_ready stays high, set by the single rotation stage per pipeline register.
// Every stage has its own valid bit and loads whenever it is empty or the stage after
// it moves, so bubbles close up and a new item is taken while a finished result waits
// in the output register. When the receiver stalls, the pipeline fills and s_ready
// falls only once every stage holds an item; nothing is dropped or repeated.
// Reset (aresetn low at a clock edge) empties all stages; there is no other state.
module bearing_to_point_turns #(
    parameter int ROTATION_STAGES = 16,
    parameter int ANGLE_BITS      = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [31:0]            s_agent_left,
    input  logic signed [31:0]            s_agent_top,
    input  logic        [15:0]            s_agent_width,
    input  logic        [15:0]            s_agent_height,
    input  logic signed [31:0]            s_point_x,
    input  logic signed [31:0]            s_point_y,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic        [bttp_pkg::OUT_W-1:0] m_bearing
);
    import bttp_pkg::*;

    // Rotation stages actually built; the table holds 24 angles.
    localparam int NSTG = (ROTATION_STAGES < TABLE_LEN) ? ROTATION_STAGES : TABLE_LEN;
    // Table bits dropped when rounding Q0.32 angles to ANGLE_BITS.
    localparam int DROP = 32 - ANGLE_BITS;

    typedef logic signed [DATA_W-1:0] vec_t;
    typedef logic [ANGLE_BITS-1:0]    ang_t;

    // Offset stage.
    logic  dxy_vld_reg;
    vec_t  dx_reg;
    vec_t  dy_reg;
    vec_t  dx_next;
    vec_t  dy_next;
    logic  dxy_ld;

    // Rotation pipeline: position 0 is the set-up vector, position k is after k stages.
    logic             vld_reg  [0:NSTG];
    vec_t             u_reg    [0:NSTG];
    vec_t             v_reg    [0:NSTG];
    ang_t             acc_reg  [0:NSTG];
    logic             sp_reg   [0:NSTG];
    logic [OUT_W-1:0] spv_reg  [0:NSTG];
    vec_t             u0_next;
    vec_t             v0_next;
    ang_t             acc0_next;
    vec_t             u_next   [1:NSTG];
    vec_t             v_next   [1:NSTG];
    ang_t             acc_next [1:NSTG];
    logic             sp_next;
    logic [OUT_W-1:0] spv_next;
    logic             ld       [0:NSTG];

    // Output register.
    logic             m_valid_reg;
    logic [OUT_W-1:0] m_bearing_reg;
    logic [OUT_W-1:0] m_bearing_next;
    logic [OUT_W-1:0] conv_bearing;
    logic             out_ld;

    // ---------------------------------------------------------------------------------
    // Load enables: a stage loads when it is empty or the stage after it loads.
    // ---------------------------------------------------------------------------------
    always_comb begin
        out_ld = !m_valid_reg || m_ready;
        ld[NSTG] = !vld_reg[NSTG] || out_ld;
        for (int k = NSTG - 1; k >= 0; k--) begin
            ld[k] = !vld_reg[k] || ld[k+1];
        end
        dxy_ld = !dxy_vld_reg || ld[0];
    end

    assign s_ready   = dxy_ld;
    assign m_valid   = m_valid_reg;
    assign m_bearing = m_bearing_reg;

    // ---------------------------------------------------------------------------------
    // Offset from the agent centre. Half the size in Q.8 is size * 128.
    // ---------------------------------------------------------------------------------
    always_comb begin
        vec_t left_x;
        vec_t top_x;
        vec_t px_x;
        vec_t py_x;
        vec_t w_x;
        vec_t h_x;
        left_x  = {{(DATA_W-32){s_agent_left[31]}}, s_agent_left};
        top_x   = {{(DATA_W-32){s_agent_top[31]}}, s_agent_top};
        px_x    = {{(DATA_W-32){s_point_x[31]}}, s_point_x};
        py_x    = {{(DATA_W-32){s_point_y[31]}}, s_point_y};
        w_x     = {{(DATA_W-23){1'b0}}, s_agent_width, 7'b0};
        h_x     = {{(DATA_W-23){1'b0}}, s_agent_height, 7'b0};
        dx_next = px_x - (left_x + w_x);
        dy_next = py_x - (top_x + h_x);
    end

    // ---------------------------------------------------------------------------------
    // Set-up: axis-aligned offsets are answered directly. Otherwise u points north and
    // v east; a target south of the centre is turned by half a turn first.
    // ---------------------------------------------------------------------------------
    always_comb begin
        logic dx_zero;
        logic dy_zero;
        dx_zero = (dx_reg == '0);
        dy_zero = (dy_reg == '0);
        sp_next  = dx_zero || dy_zero;
        spv_next = BEARING_NORTH;
        if (dy_zero) begin
            if (dx_zero) begin
                spv_next = BEARING_NORTH;
            end else if (dx_reg[DATA_W-1]) begin
                spv_next = BEARING_WEST;
            end else begin
                spv_next = BEARING_EAST;
            end
        end else if (dx_zero) begin
            spv_next = dy_reg[DATA_W-1] ? BEARING_NORTH : BEARING_SOUTH;
        end

        if (!dy_reg[DATA_W-1] && !dy_zero) begin
            u0_next   = dy_reg;
            v0_next   = -dx_reg;
            acc0_next = ang_t'(1) << (ANGLE_BITS - 1);
        end else begin
            u0_next   = -dy_reg;
            v0_next   = dx_reg;
            acc0_next = '0;
        end
    end

    // ---------------------------------------------------------------------------------
    // Rotation stages: each drives v toward zero and adds the turned angle.
    // ---------------------------------------------------------------------------------
    always_comb begin
        logic [32:0] q_ext;
        logic [32:0] entry;
        for (int k = 0; k < NSTG; k++) begin
            q_ext = {1'b0, ATAN_TURNS_Q32[k]} + (33'd1 << (DROP - 1));
            entry = q_ext >> DROP;
            if (!v_reg[k][DATA_W-1] && (v_reg[k] != '0)) begin
                u_next[k+1]   = u_reg[k] + (v_reg[k] >>> k);
                v_next[k+1]   = v_reg[k] - (u_reg[k] >>> k);
                acc_next[k+1] = acc_reg[k] + entry[ANGLE_BITS-1:0];
            end else begin
                u_next[k+1]   = u_reg[k] - (v_reg[k] >>> k);
                v_next[k+1]   = v_reg[k] + (u_reg[k] >>> k);
                acc_next[k+1] = acc_reg[k] - entry[ANGLE_BITS-1:0];
            end
        end
    end

    // ---------------------------------------------------------------------------------
    // Angle to 16 fraction bits: round half-up when wider, pad with zeros when narrower.
    // ---------------------------------------------------------------------------------
    generate
        if (ANGLE_BITS > OUT_W) begin : g_round
            localparam int SH = ANGLE_BITS - OUT_W;
            logic [ANGLE_BITS:0] rsum;
            assign rsum = {1'b0, acc_reg[NSTG]} + ((ANGLE_BITS+1)'(1) << (SH - 1));
            assign conv_bearing = rsum[SH+OUT_W-1:SH];
        end else if (ANGLE_BITS < OUT_W) begin : g_pad
            assign conv_bearing = {acc_reg[NSTG], {(OUT_W-ANGLE_BITS){1'b0}}};
        end else begin : g_same
            assign conv_bearing = acc_reg[NSTG];
        end
    endgenerate

    assign m_bearing_next = sp_reg[NSTG] ? spv_reg[NSTG] : conv_bearing;

    // ---------------------------------------------------------------------------------
    // Valid bits.
    // ---------------------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dxy_vld_reg <= 1'b0;
            for (int k = 0; k <= NSTG; k++) begin
                vld_reg[k] <= 1'b0;
            end
            m_valid_reg <= 1'b0;
        end else begin
            if (dxy_ld) begin
                dxy_vld_reg <= s_valid;
            end
            if (ld[0]) begin
                vld_reg[0] <= dxy_vld_reg;
            end
            for (int k = 1; k <= NSTG; k++) begin
                if (ld[k]) begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
            if (out_ld) begin
                m_valid_reg <= vld_reg[NSTG];
            end
        end
    end

    // ---------------------------------------------------------------------------------
    // Payload registers.
    // ---------------------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (dxy_ld) begin
            dx_reg <= dx_next;
            dy_reg <= dy_next;
        end
        if (ld[0]) begin
            u_reg[0]   <= u0_next;
            v_reg[0]   <= v0_next;
            acc_reg[0] <= acc0_next;
            sp_reg[0]  <= sp_next;
            spv_reg[0] <= spv_next;
        end
        for (int k = 1; k <= NSTG; k++) begin
            if (ld[k]) begin
                u_reg[k]   <= u_next[k];
                v_reg[k]   <= v_next[k];
                acc_reg[k] <= acc_next[k];
                sp_reg[k]  <= sp_reg[k-1];
                spv_reg[k] <= spv_reg[k-1];
            end
        end
        if (out_ld) begin
            m_bearing_reg <= m_bearing_next;
        end
    end

endmodule
